>>> rtl/n2a_pkg.sv
// Package for the number to ASCII converter.
// Holds mode codes, field widths, ASCII offsets and the digit helpers.
// No dependencies.
package n2a_pkg;

  // Field widths of the input and result transactions.
  localparam int OP_W    = 2;
  localparam int VALUE_W = 64;
  localparam int CHAR_W  = 7;

  // Conversion mode codes.
  localparam logic [OP_W-1:0] OP_DEC   = 2'd0;
  localparam logic [OP_W-1:0] OP_HEX   = 2'd1;
  localparam logic [OP_W-1:0] OP_HEX12 = 2'd2;

  // Decimal conversion works on the low 32 bits and yields up to ten digits.
  localparam int DEC_BITS   = 32;
  localparam int DEC_DIGITS = 10;
  localparam int BCD_W      = DEC_DIGITS * 4;

  // Counter wide enough for the shift cycles and the digit count.
  localparam int CNT_W = 5;

  localparam logic [CHAR_W-1:0] ASCII_ZERO      = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_ALPHA_OFS = 7'd55;

  typedef logic [3:0] nibble_t;

  // Maps one hex or BCD digit to its uppercase ASCII code.
  function automatic logic [CHAR_W-1:0] nibble_to_ascii(input nibble_t nib);
    logic [CHAR_W-1:0] ext;
    ext = {3'b000, nib};
    if (nib < 4'd10) begin
      return ext + ASCII_ZERO;
    end else begin
      return ext + ASCII_ALPHA_OFS;
    end
  endfunction

  // One double-dabble correction: a BCD digit of five or more gets three added.
  function automatic nibble_t bcd_adjust(input nibble_t d);
    if (d >= 4'd5) begin
      return d + 4'd3;
    end else begin
      return d;
    end
  endfunction

endpackage

>>> rtl/number_to_ascii_converter_top.sv
// Top level of the number to ASCII converter: decimal and hex digit emission.
// Depends on n2a_pkg for mode codes, widths and digit helpers.
//
//   Channel | Ports                          | Direction
//   --------+--------------------------------+----------
//   input   | in_valid in_stall in_op in_value | in (stall out)
//   result  | out_valid out_stall out_char_code out_last | out (stall in)
//
// Hex modes: the value is loaded, then one character per cycle unless the result is stalled
// (2 to 16 characters). Decimal mode: serial binary to BCD shifting, then leading zero
// digits are dropped (up to 9), then emission starts with one character per cycle unless
// the result is stalled (1 to 10 characters).
// One number is worked on at a time; in_stall stays high until its last
// character has been loaded into the output register.
// Reset (synchronous, active low) returns the controller to idle and empties the
// output register. A stalled result only holds the emission step.
module number_to_ascii_converter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [n2a_pkg::OP_W-1:0]      in_op,
  input  logic [n2a_pkg::VALUE_W-1:0]   in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [n2a_pkg::CHAR_W-1:0]    out_char_code,
  output logic                          out_last
);
  import n2a_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [VALUE_W-1:0] data_r, data_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  logic               in_accept;
  logic               out_free;
  logic [BCD_W-1:0]   bcd_adj;
  logic [BCD_W-1:0]   bcd_shift;
  nibble_t            top_nib;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign top_nib   = data_r[VALUE_W-1 -: 4];

  // Double-dabble step: correct each BCD digit, then shift in the next binary bit.
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = bcd_adjust(bcd_r[i*4 +: 4]);
    end
    bcd_shift = {bcd_adj[BCD_W-2:0], data_r[VALUE_W-1]};
  end

  // Controller and datapath next-state logic.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    data_nxt      = data_r;
    bcd_nxt       = bcd_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_op)
            OP_DEC: begin
              data_nxt  = {in_value[DEC_BITS-1:0], {(VALUE_W-DEC_BITS){1'b0}}};
              bcd_nxt   = '0;
              cnt_nxt   = CNT_W'(DEC_BITS - 1);
              state_nxt = ST_CONV;
            end
            OP_HEX: begin
              // Align the first digit to the top nibble of the shift register.
              if (in_value[63:32] != '0) begin
                data_nxt = in_value;
                cnt_nxt  = CNT_W'(15);
              end else if (in_value[31:16] != '0) begin
                data_nxt = {in_value[31:0], 32'd0};
                cnt_nxt  = CNT_W'(7);
              end else if (in_value[15:8] != '0) begin
                data_nxt = {in_value[15:0], 48'd0};
                cnt_nxt  = CNT_W'(3);
              end else begin
                data_nxt = {in_value[7:0], 56'd0};
                cnt_nxt  = CNT_W'(1);
              end
              state_nxt = ST_EMIT;
            end
            OP_HEX12: begin
              data_nxt  = {in_value[47:0], 16'd0};
              cnt_nxt   = CNT_W'(11);
              state_nxt = ST_EMIT;
            end
            default: begin
              // Unused mode: the transaction is taken and dropped.
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_CONV: begin
        data_nxt = {data_r[VALUE_W-2:0], 1'b0};
        if (cnt_r == '0) begin
          // Conversion done: move the ten BCD digits to the top of the shift register.
          data_nxt  = {bcd_shift, {(VALUE_W-BCD_W){1'b0}}};
          cnt_nxt   = CNT_W'(DEC_DIGITS - 1);
          state_nxt = ST_SKIP;
        end else begin
          bcd_nxt = bcd_shift;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_SKIP: begin
        // Drop leading zero digits, but always keep the last one.
        if (top_nib == 4'd0 && cnt_r != '0) begin
          data_nxt = {data_r[VALUE_W-5:0], 4'd0};
          cnt_nxt  = cnt_r - 1'b1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = nibble_to_ascii(top_nib);
          out_last_nxt  = (cnt_r == '0);
          data_nxt      = {data_r[VALUE_W-5:0], 4'd0};
          if (cnt_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    data_r     <= data_nxt;
    bcd_r      <= bcd_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

endmodule

>>> tb/sv/tb_number_to_ascii_converter_top.sv
// Self-checking testbench for number_to_ascii_converter_top: decimal, hex and hex-12 digits.
// Predicts every character from the mode and value, with random idling on both channels.
// Depends on n2a_pkg and the converter RTL.
`timescale 1ns / 100ps

module tb_number_to_ascii_converter_top;
  import n2a_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 4;
  localparam int RANDOM_ITEMS   = 500;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 100;
  localparam int MAX_GAP        = 5;

  // Receiver plan, counted in characters: one long hold-off inside a stretch without idling.
  localparam int LONG_HOLD_AT  = 1000;
  localparam int LONG_HOLD     = 300;
  localparam int RX_BUSY_FROM  = 800;
  localparam int RX_BUSY_TO    = 1600;

  // Mode code that the block ignores.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // One number waiting to be sent, with the idle cycles that come before it.
  typedef struct {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    int                 gap;
    bit                 drain;
  } conv_req_t;

  // One character expected on the result channel.
  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
  } ascii_char_t;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic [OP_W-1:0]    in_op         = '0;
  logic [VALUE_W-1:0] in_value      = '0;
  logic               out_stall     = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [CHAR_W-1:0]  out_char_code;
  logic               out_last;

  conv_req_t   pending[$];
  ascii_char_t expected_chars[$];
  int          gap_left     = 0;
  int          hold_left    = 0;
  int          chars_seen   = 0;
  int          mismatches   = 0;
  int          quiet_cycles = 0;

  number_to_ascii_converter_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_code(out_char_code),
    .out_last     (out_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Works out the characters that one number produces and queues them.
  task automatic predict_digits(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
    logic [31:0]       rest;
    logic [3:0]        nib;
    logic [CHAR_W-1:0] code;
    int                digits[$];
    int                ndig;
    ascii_char_t       ch;
    case (op)
      OP_DEC: begin
        // Decimal: low 32 bits, leading zeros dropped, zero gives a single digit.
        rest = value[31:0];
        do begin
          digits.push_front(int'(rest % 32'd10));
          rest = rest / 32'd10;
        end while (rest != 0);
        foreach (digits[i]) begin
          nib = digits[i][3:0];
          ch.code = ASCII_ZERO + {3'b000, nib};
          ch.last = (i == digits.size() - 1);
          expected_chars.push_back(ch);
        end
      end
      OP_HEX, OP_HEX12: begin
        // Hex: the width follows the highest nonzero byte range, or is fixed at twelve.
        if (op == OP_HEX12) ndig = 12;
        else if (|value[63:32]) ndig = 16;
        else if (|value[31:16]) ndig = 8;
        else if (|value[15:8]) ndig = 4;
        else ndig = 2;
        for (int i = ndig - 1; i >= 0; i--) begin
          nib = value[i*4 +: 4];
          code = (nib < 4'd10) ? ASCII_ZERO + {3'b000, nib} : ASCII_ALPHA_OFS + {3'b000, nib};
          ch.code = code;
          ch.last = (i == 0);
          expected_chars.push_back(ch);
        end
      end
      default: begin
        // The unused mode produces nothing.
      end
    endcase
  endtask

  task automatic add_number(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                            input int gap, input bit drain);
    conv_req_t req;
    req.op = op;
    req.value = value;
    req.gap = gap;
    req.drain = drain;
    pending.push_back(req);
  endtask

  // Random value whose significant width varies, so every digit count shows up.
  function automatic logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return v;
      1: return v >> $urandom_range(0, 64);
      2: return v & 64'h0000_0000_FFFF_FFFF;
      default: return v >> (32 + $urandom_range(0, 31));
    endcase
  endfunction

  // Driver: offers queued numbers, predicts each accepted transaction.
  always @(posedge clk) begin : feed_numbers
    conv_req_t req;
    logic      offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      offer = in_valid;
      if (in_valid && !in_stall) begin
        predict_digits(in_op, in_value);
        offer = 1'b0;
        if (pending.size() > 0) gap_left = pending[0].gap;
      end
      if (!offer && pending.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!pending[0].drain || expected_chars.size() == 0) begin
          req = pending.pop_front();
          in_op <= req.op;
          in_value <= req.value;
          offer = 1'b1;
        end
      end
      in_valid <= offer;
    end
  end

  // Monitor: checks each accepted character and draws the stall before the next one.
  always @(posedge clk) begin : check_chars
    ascii_char_t exp_char;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("character 0x%0h with none expected", out_char_code));
        end else begin
          exp_char = expected_chars.pop_front();
          if (out_char_code !== exp_char.code)
            report_mismatch($sformatf("char_code 0x%0h, expected 0x%0h",
                                      out_char_code, exp_char.code));
          if (out_last !== exp_char.last)
            report_mismatch($sformatf("last %b, expected %b", out_last, exp_char.last));
        end
        chars_seen++;
        if (chars_seen == LONG_HOLD_AT) hold_left = LONG_HOLD;
        else if (chars_seen < RX_BUSY_FROM || chars_seen >= RX_BUSY_TO)
          hold_left = $urandom_range(0, MAX_GAP);
        else hold_left = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int               counted;
    int               r;
    int               gap;
    logic [OP_W-1:0]  op;

    // Directed numbers: extremes, every mode, ignored high bits and the unused mode.
    add_number(OP_DEC, 64'd0, 0, 1'b0);
    add_number(OP_DEC, 64'd1, 0, 1'b0);
    add_number(OP_DEC, 64'd9, 2, 1'b0);
    add_number(OP_DEC, 64'd10, 0, 1'b0);
    add_number(OP_DEC, 64'd1000000000, 3, 1'b0);
    add_number(OP_DEC, 64'h0000_0000_FFFF_FFFF, 0, 1'b0);
    add_number(OP_DEC, 64'hFFFF_FFFF_0000_0000, 1, 1'b0);
    add_number(OP_DEC, 64'hDEAD_BEEF_0000_007B, 0, 1'b0);
    add_number(OP_HEX, 64'h0, 0, 1'b0);
    add_number(OP_HEX, 64'hFF, 4, 1'b0);
    add_number(OP_HEX, 64'h100, 0, 1'b0);
    add_number(OP_HEX, 64'hFFFF, 0, 1'b0);
    add_number(OP_HEX, 64'h1_0000, 5, 1'b0);
    add_number(OP_HEX, 64'hFFFF_FFFF, 0, 1'b0);
    add_number(OP_HEX, 64'h1_0000_0000, 0, 1'b0);
    add_number(OP_HEX, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1'b0);
    add_number(OP_HEX, 64'hFEDC_BA98_7654_3210, 0, 1'b0);
    add_number(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0);
    add_number(OP_HEX12, 64'h0, 0, 1'b0);
    add_number(OP_HEX12, 64'hFFFF_FFFF_FFFF_FFFF, 2, 1'b0);
    add_number(OP_HEX12, 64'h0000_0123_4567_89AB, 0, 1'b0);
    add_number(OP_HEX12, 64'hFFFF_0000_0000_0000, 0, 1'b0);
    add_number(OP_UNUSED, 64'h0, 3, 1'b0);
    add_number(OP_DEC, 64'd4294967295, 0, 1'b1);

    // Random numbers; one stretch without sender gaps covers the long receiver hold-off,
    // and two drained pauses wait for every pending character first.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      r = $urandom_range(0, 19);
      op = (r == 0) ? OP_UNUSED : 2'(r % 3);
      gap = (counted >= 60 && counted < 220) ? 0 : $urandom_range(0, MAX_GAP);
      add_number(op, rand_value(), gap, counted == 40 || counted == 300);
      if (op != OP_UNUSED) counted++;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Let everything drain, then allow the block's latency to pass for stray output.
    while (pending.size() > 0 || in_valid || expected_chars.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/n2a_pkg.sv
rtl/number_to_ascii_converter_top.sv
tb/sv/tb_number_to_ascii_converter_top.sv
